FILE: rtl/nbt_pkg.sv
// nbt_pkg: shared types, codes and constants of the name binding table
// used by every module of the block but nbt_ram; depends on nothing

package nbt_pkg;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 200;
    localparam int M_TDATA_W = 72;
    localparam int IN_NAME_W = 128;
    localparam int WORD_W    = 32;

    // character codes
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
    localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;
    localparam logic [7:0] CASE_OFFSET     = 8'h20;

    typedef enum logic [1:0] {
        ACT_BIND   = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_UNBIND = 2'd2,
        ACT_RSVD   = 2'd3
    } nbt_action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } nbt_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CANON,
        S_CHECK,
        S_SEARCH,
        S_MOVE,
        S_RESP
    } nbt_state_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_HIT,
        WR_APPEND,
        WR_MOVE
    } nbt_wr_t;

    // controller to datapath
    typedef struct packed {
        logic        load;
        logic        canon;
        logic        search_start;
        logic        scan;
        logic        rd_last;
        nbt_wr_t     wr_sel;
        logic        res_load;
        nbt_status_t res_status;
        logic        res_take_data;
        logic        push_out;
    } nbt_cmd_t;

    // datapath to controller
    typedef struct packed {
        nbt_action_t action;
        logic        name_ok;
        logic        arg_zero;
        logic        hit;
        logic        miss;
        logic        full;
        logic        out_free;
    } nbt_stat_t;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            r = c - CASE_OFFSET;
        return r;
    endfunction

    function automatic logic legal_char(input logic [7:0] c);
        return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
               (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) ||
               (c == CHAR_UNDERSCORE);
    endfunction

endpackage

FILE: rtl/nbt_ram.sv
// nbt_ram: generic single write port, single read port ram, registered read
// no dependencies

module nbt_ram #(
    parameter int WIDTH = 192,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/nbt_ctrl.sv
// nbt_ctrl: request sequencer of the name binding table
// depends on nbt_pkg; drives nbt_dp through command and status structs

module nbt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  nbt_pkg::nbt_stat_t stat,
    output nbt_pkg::nbt_cmd_t  cmd
);

    import nbt_pkg::*;

    nbt_state_t state_reg;
    nbt_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.wr_sel = WR_NONE;
        cmd.res_status = ST_OK;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CANON;
                end
            end
            S_CANON:
            begin
                cmd.canon  = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if ((stat.action == ACT_BIND && stat.name_ok && !stat.arg_zero) ||
                    ((stat.action == ACT_LOOKUP || stat.action == ACT_UNBIND) &&
                     stat.name_ok))
                begin
                    cmd.search_start = 1'b1;
                    state_next       = S_SEARCH;
                end
                else
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_INVALID;
                    state_next     = S_RESP;
                end
            end
            S_SEARCH:
            begin
                if (stat.hit)
                begin
                    case (stat.action)
                        ACT_BIND:
                        begin
                            cmd.wr_sel     = WR_HIT;
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_OK;
                            state_next     = S_RESP;
                        end
                        ACT_LOOKUP:
                        begin
                            cmd.res_load      = 1'b1;
                            cmd.res_status    = ST_OK;
                            cmd.res_take_data = 1'b1;
                            state_next        = S_RESP;
                        end
                        ACT_UNBIND:
                        begin
                            cmd.rd_last = 1'b1;
                            state_next  = S_MOVE;
                        end
                        default:
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_INVALID;
                            state_next     = S_RESP;
                        end
                    endcase
                end
                else if (stat.miss)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_RESP;
                    if (stat.action == ACT_BIND)
                    begin
                        if (stat.full)
                            cmd.res_status = ST_FULL;
                        else
                        begin
                            cmd.wr_sel     = WR_APPEND;
                            cmd.res_status = ST_OK;
                        end
                    end
                    else
                        cmd.res_status = ST_NOT_FOUND;
                end
                else
                    cmd.scan = 1'b1;
            end
            S_MOVE:
            begin
                cmd.wr_sel     = WR_MOVE;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
                state_next     = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.push_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

FILE: rtl/nbt_dp.sv
// nbt_dp: request registers, name canonicalizer, table scan and result path
// depends on nbt_pkg and nbt_ram; commanded by nbt_ctrl

module nbt_dp #(
    parameter int TABLE_ENTRIES = 16,
    parameter int NAME_BYTES    = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [nbt_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [nbt_pkg::M_TDATA_W-1:0]     m_tdata,
    input  nbt_pkg::nbt_cmd_t                 cmd,
    output nbt_pkg::nbt_stat_t                stat
);

    import nbt_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int NAME_W = 8 * NAME_BYTES;
    localparam int ENT_W  = NAME_W + 2 * WORD_W;
    localparam logic [15:0] NB_MASK = 16'((32'd1 << NAME_BYTES) - 32'd1);

    // request registers
    nbt_action_t          action_reg;
    logic [IN_NAME_W-1:0] name_in_reg;
    logic [WORD_W-1:0]    handle_reg;
    logic [WORD_W-1:0]    rights_reg;
    logic [NAME_W-1:0]    canon_reg;
    logic [NAME_W-1:0]    canon_next;
    logic                 name_ok_reg;
    logic                 name_ok_next;

    // table control
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] rd_ptr_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             cmp_valid_reg;

    // result and output
    nbt_status_t       res_status_reg;
    logic [WORD_W-1:0] res_handle_reg;
    logic [WORD_W-1:0] res_rights_reg;
    logic              m_tvalid_reg;
    nbt_status_t       out_status_reg;
    logic [WORD_W-1:0] out_handle_reg;
    logic [WORD_W-1:0] out_rights_reg;

    // ram ports
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;
    logic             scan_issue;
    logic             name_match;
    logic [IDX_W-1:0] last_idx;

    // canonicalizer: uppercase, stop at first zero, check characters
    always_comb
    begin
        logic [15:0] zero_v;
        logic [7:0]  c;
        logic [7:0]  up;
        logic        prior;
        logic        bad;
        zero_v     = '0;
        canon_next = '0;
        bad        = 1'b0;
        for (int i = 0; i < 16; i++)
            zero_v[i] = (name_in_reg[8*i +: 8] == 8'h00);
        for (int i = 0; i < NAME_BYTES; i++)
        begin
            c     = name_in_reg[8*i +: 8];
            up    = to_upper(c);
            prior = |(zero_v & 16'((32'd1 << i) - 32'd1));
            if (!prior && !zero_v[i] && !legal_char(up))
                bad = 1'b1;
            canon_next[8*i +: 8] = (prior || zero_v[i]) ? 8'h00 : up;
        end
        name_ok_next = !zero_v[0] && (|(zero_v & NB_MASK)) && !bad;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg  <= nbt_action_t'(s_tdata[1:0]);
            name_in_reg <= s_tdata[129:2];
            handle_reg  <= s_tdata[161:130];
            rights_reg  <= s_tdata[193:162];
        end
        if (cmd.canon)
        begin
            canon_reg   <= canon_next;
            name_ok_reg <= name_ok_next;
        end
        if (scan_issue)
            cmp_idx_reg <= rd_ptr_reg[IDX_W-1:0];
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_handle_reg <= cmd.res_take_data ? ram_rdata[NAME_W +: WORD_W] : '0;
            res_rights_reg <= cmd.res_take_data ? ram_rdata[NAME_W+WORD_W +: WORD_W] : '0;
        end
        if (cmd.push_out)
        begin
            out_status_reg <= res_status_reg;
            out_handle_reg <= res_handle_reg;
            out_rights_reg <= res_rights_reg;
        end
    end

    // scan: issue a read each cycle, compare the previous read
    assign scan_issue = cmd.scan && (rd_ptr_reg < count_reg);
    assign name_match = (ram_rdata[NAME_W-1:0] == canon_reg);
    assign last_idx   = IDX_W'(count_reg - CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            cmp_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.search_start)
            begin
                rd_ptr_reg    <= '0;
                cmp_valid_reg <= 1'b0;
            end
            else if (cmd.scan)
            begin
                cmp_valid_reg <= scan_issue;
                if (scan_issue)
                    rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
            end
            if (cmd.wr_sel == WR_APPEND)
                count_reg <= count_reg + CNT_W'(1);
            else if (cmd.wr_sel == WR_MOVE)
                count_reg <= count_reg - CNT_W'(1);
            if (cmd.push_out)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cmp_idx_reg;
        ram_wdata = {rights_reg, handle_reg, canon_reg};
        case (cmd.wr_sel)
            WR_HIT:
                ram_we = 1'b1;
            WR_APPEND:
            begin
                ram_we    = 1'b1;
                ram_waddr = count_reg[IDX_W-1:0];
            end
            WR_MOVE:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            default:
                ram_we = 1'b0;
        endcase
    end

    assign ram_re    = scan_issue || cmd.rd_last;
    assign ram_raddr = cmd.rd_last ? last_idx : rd_ptr_reg[IDX_W-1:0];

    nbt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        stat.action   = action_reg;
        stat.name_ok  = name_ok_reg;
        stat.arg_zero = (handle_reg == '0) || (rights_reg == '0);
        stat.hit      = cmp_valid_reg && name_match;
        stat.miss     = !cmp_valid_reg && (rd_ptr_reg >= count_reg);
        stat.full     = (count_reg == CNT_W'(TABLE_ENTRIES));
        stat.out_free = !m_tvalid_reg || m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, out_rights_reg, out_handle_reg, out_status_reg};

endmodule

FILE: rtl/name_binding_table_core.sv
// name_binding_table_core: top level of the name binding table
// depends on nbt_pkg, nbt_ctrl, nbt_dp (which holds nbt_ram)
//
// usage
// - slave stream takes one request per handshake: action, a zero padded name
//   of up to NAME_BYTES bytes, and the handle and rights word for a bind
// - master stream returns exactly one result per request: status, and the
//   handle and rights of the entry on a successful lookup (zero otherwise)
// - names are uppercased; empty names, names of NAME_BYTES or more chars and
//   names with chars outside A-Z, 0-9 and underscore are rejected
// - a rejected request goes from canonicalize and check straight to the
//   response; a searched one scans the live entries in order, stopping on
//   a hit; an unbind hit then moves the last entry into the freed slot
// - the search time is set by the linear scan: one table ram read per entry,
//   the ram having a single registered read port
// - one request at a time: s_tready is high only while the sequencer is idle;
//   it rises again as soon as the result sits in the output register, so the
//   next request is taken while that result still waits
// - reset empties the table at once (entry count cleared); no clearing pass
// - when the receiver stalls the result holds in the output register and the
//   sequencer waits with the following result until the register frees

module name_binding_table_core #(
    parameter int TABLE_ENTRIES = 16,
    parameter int NAME_BYTES    = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // action[1:0], name_low_bytes[65:2], name_high_bytes[129:66],
    // handle[161:130], rights[193:162], zero fill [199:194]
    input  logic [nbt_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // status[1:0], found_handle[33:2], found_rights[65:34], zero fill [71:66]
    output logic [nbt_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);

    import nbt_pkg::*;

    nbt_cmd_t  cmd;
    nbt_stat_t stat;

    // sequencer: accept, canonicalize, check, scan, write back, respond
    nbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // request registers, table ram and output register
    nbt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .NAME_BYTES    (NAME_BYTES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

FILE: rtl/nbt_checker.sv
// nbt_checker: port level checks of name_binding_table_core, bound to the top
// depends on nbt_pkg

module nbt_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [nbt_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready
);

    import nbt_pkg::*;

    // one request in flight: nothing is taken right after an accept
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    // a failed request carries no handle or rights
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[1:0] != ST_OK) |-> (m_tdata[65:2] == '0))
        else $error("failed result carries data");

    // bound entries always have both handle and rights nonzero, so a nonzero found handle comes with nonzero rights
    a_pair_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[33:2] != '0) |-> (m_tdata[65:34] != '0))
        else $error("found handle without rights");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind name_binding_table_core nbt_checker u_nbt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

FILE: dv/name_binding_table_core_tb.sv
// name_binding_table_core_tb: self-checking bench for the name binding table core
// stream driver and checker run as clocked always blocks; a scoreboard model tracks the bindings
// depends on nbt_pkg and name_binding_table_core

module name_binding_table_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import nbt_pkg::*;

    localparam int ENTRIES    = 16;
    localparam int NAME_LEN   = 16;
    localparam int POOL_SIZE  = 20;
    localparam int RANDOM_REQ = 1250;
    localparam int HOLD_CYCLES = 600;
    localparam string NAME_CHARS = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

    // request as laid out on s_tdata, last field in the lowest bits
    typedef struct packed {
        logic [5:0]  fill;
        logic [31:0] rights;
        logic [31:0] handle;
        logic [63:0] name_hi;
        logic [63:0] name_lo;
        nbt_action_t action;
    } request_t;

    // reply as laid out on m_tdata
    typedef struct packed {
        logic [5:0]  fill;
        logic [31:0] rights;
        logic [31:0] handle;
        nbt_status_t status;
    } reply_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    // bindings as the block should hold them
    logic [127:0] book_name   [ENTRIES];
    logic [31:0]  book_handle [ENTRIES];
    logic [31:0]  book_rights [ENTRIES];
    int           book_count = 0;

    request_t request_q[$];
    reply_t   reply_q[$];

    // canonical names used for well-formed traffic
    logic [127:0] pool_name [POOL_SIZE];
    int           pool_len  [POOL_SIZE];

    int     errors = 0;
    int     replies_seen = 0;
    int     send_gap, send_calm, recv_gap, recv_calm;
    logic   hold_off = 1'b0;
    reply_t got_reply, want_reply;

    name_binding_table_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit name_char(input logic [7:0] c);
        return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
               (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) || c == CHAR_UNDERSCORE;
    endfunction

    function automatic bit is_lower(input logic [7:0] c);
        return c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z;
    endfunction

    // uppercase the name up to its terminator; 0 when the name is rejected
    function automatic bit fold_name(input logic [127:0] raw, output logic [127:0] canon);
        logic [7:0] c;
        bit         ok;
        bit         done;
        canon = '0;
        ok    = 1'b0;
        done  = 1'b0;
        for (int i = 0; i < NAME_LEN; i++)
        begin
            c = raw[8*i +: 8];
            if (!done)
            begin
                if (c == 8'h00)
                begin
                    ok   = (i != 0);
                    done = 1'b1;
                end
                else if (i == NAME_LEN - 1)
                    done = 1'b1;        // no room left for the terminator
                else
                begin
                    if (is_lower(c))
                        c = c - CASE_OFFSET;
                    if (name_char(c))
                        canon[8*i +: 8] = c;
                    else
                        done = 1'b1;
                end
            end
        end
        return ok;
    endfunction

    // apply one request to the bindings and return the reply it should give
    function automatic reply_t apply_request(input request_t req);
        reply_t       rep;
        logic [127:0] key;
        bit           ok;
        int           hit;
        rep        = '0;
        rep.status = ST_INVALID;
        ok         = fold_name({req.name_hi, req.name_lo}, key);
        hit        = -1;
        for (int i = 0; i < book_count; i++)
            if (hit < 0 && book_name[i] == key)
                hit = i;
        case (req.action)
            ACT_BIND:
                if (ok && req.handle != 0 && req.rights != 0)
                begin
                    rep.status = ST_OK;
                    if (hit >= 0)
                    begin
                        book_handle[hit] = req.handle;
                        book_rights[hit] = req.rights;
                    end
                    else if (book_count >= ENTRIES)
                        rep.status = ST_FULL;
                    else
                    begin
                        book_name[book_count]   = key;
                        book_handle[book_count] = req.handle;
                        book_rights[book_count] = req.rights;
                        book_count++;
                    end
                end
            ACT_LOOKUP:
                if (ok)
                begin
                    if (hit >= 0)
                    begin
                        rep.status = ST_OK;
                        rep.handle = book_handle[hit];
                        rep.rights = book_rights[hit];
                    end
                    else
                        rep.status = ST_NOT_FOUND;
                end
            ACT_UNBIND:
                if (ok)
                begin
                    if (hit >= 0)
                    begin
                        // last entry fills the hole
                        book_name[hit]   = book_name[book_count-1];
                        book_handle[hit] = book_handle[book_count-1];
                        book_rights[hit] = book_rights[book_count-1];
                        book_count--;
                        rep.status = ST_OK;
                    end
                    else
                        rep.status = ST_NOT_FOUND;
                end
            default: ;  // reserved action leaves the bindings alone
        endcase
        return rep;
    endfunction

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        case ($urandom_range(0, 19))
            0:       w = 32'hFFFF_FFFF;
            1:       w = 32'h0000_0001;
            default: w = $urandom;
        endcase
        return (w == 0) ? 32'h1 : w;
    endfunction

    function automatic int idle_len();
        int k;
        k = $urandom_range(0, 19);
        if (k < 12)
            return 0;
        if (k < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [127:0] text_name(input string s);
        logic [127:0] v;
        v = '0;
        for (int i = 0; i < s.len(); i++)
            v[8*i +: 8] = s[i];
        return v;
    endfunction

    // pool name with random case and random bytes past the terminator
    function automatic logic [127:0] dressed_name(input int k);
        logic [127:0] v;
        logic [7:0]   c;
        v = pool_name[k];
        for (int i = 0; i < NAME_LEN; i++)
        begin
            c = v[8*i +: 8];
            if (i < pool_len[k] && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z && $urandom_range(0, 1))
                v[8*i +: 8] = c + CASE_OFFSET;
            else if (i > pool_len[k] && $urandom_range(0, 2) == 0)
                v[8*i +: 8] = 8'($urandom);
        end
        return v;
    endfunction

    function automatic logic [127:0] broken_name();
        logic [127:0] v;
        logic [7:0]   c;
        int           k;
        v = rand128();
        case ($urandom_range(0, 3))
            0: ;                        // raw noise
            1: v[7:0] = 8'h00;          // empty
            2:                          // no terminator in reach
                for (int i = 0; i < NAME_LEN; i++)
                    v[8*i +: 8] = NAME_CHARS[$urandom_range(0, NAME_CHARS.len() - 1)];
            default:
            begin
                // one character outside the legal set
                k = $urandom_range(0, POOL_SIZE - 1);
                v = dressed_name(k);
                do
                    c = 8'($urandom_range(1, 255));
                while (name_char(c) || is_lower(c));
                v[8*$urandom_range(0, pool_len[k] - 1) +: 8] = c;
            end
        endcase
        return v;
    endfunction

    task automatic add_request(input nbt_action_t a, input logic [127:0] name,
                               input logic [31:0] h, input logic [31:0] r);
        request_t req;
        req         = '0;
        req.action  = a;
        req.name_lo = name[63:0];
        req.name_hi = name[127:64];
        req.handle  = h;
        req.rights  = r;
        request_q.push_back(req);
    endtask

    task automatic build_pool();
        logic [127:0] v;
        bit           dup;
        int           len;
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            do
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, NAME_LEN - 1)
                                                  : $urandom_range(2, 8);
                v = '0;
                for (int i = 0; i < len; i++)
                    v[8*i +: 8] = NAME_CHARS[$urandom_range(0, NAME_CHARS.len() - 1)];
                dup = 1'b0;
                for (int j = 0; j < k; j++)
                    if (pool_name[j] == v)
                        dup = 1'b1;
            end
            while (dup);
            pool_name[k] = v;
            pool_len[k]  = len;
        end
    endtask

    task automatic add_directed();
        logic [127:0] junk;
        junk = rand128();
        add_request(ACT_BIND,   text_name("A"), 32'hFFFF_FFFF, 32'h1);
        add_request(ACT_LOOKUP, text_name("a"), '0, '0);
        // longest legal name
        add_request(ACT_BIND,   text_name("Z9_AZ09_ZZZZZZZ"), 32'h1, 32'hFFFF_FFFF);
        add_request(ACT_LOOKUP, text_name("z9_az09_zzzzzzz"), rand_word(), rand_word());
        // one character too long, then empty with noise behind the terminator
        add_request(ACT_LOOKUP, text_name("AAAAAAAAAAAAAAAA"), '0, '0);
        add_request(ACT_LOOKUP, {junk[127:8], 8'h00}, '0, '0);
        // rebind with noise past the terminator
        add_request(ACT_BIND,   {junk[127:16], 8'h00, 8'h61}, 32'h1234_5678, 32'h8765_4321);
        add_request(ACT_LOOKUP, text_name("A"), '0, '0);
        add_request(ACT_BIND,   text_name("A"), 32'h0, 32'h5);
        add_request(ACT_BIND,   text_name("A"), 32'h5, 32'h0);
        add_request(ACT_LOOKUP, text_name("A@"), '0, '0);
        add_request(ACT_LOOKUP, text_name("{A"), '0, '0);
        add_request(ACT_RSVD,   text_name("A"), 32'h7, 32'h7);
        add_request(ACT_UNBIND, text_name("NOPE"), '0, '0);
        add_request(ACT_LOOKUP, text_name("B"), '0, '0);
        // unbind of the first entry pulls the last one forward
        add_request(ACT_UNBIND, text_name("A"), '0, '0);
        add_request(ACT_LOOKUP, text_name("Z9_AZ09_ZZZZZZZ"), '0, '0);
        // fill up, overflow, and rebind while full
        for (int k = 0; k < ENTRIES - 1; k++)
            add_request(ACT_BIND, dressed_name(k), rand_word(), rand_word());
        add_request(ACT_BIND,   dressed_name(ENTRIES - 1), rand_word(), rand_word());
        add_request(ACT_BIND,   dressed_name(0), 32'hCAFE_0001, 32'hCAFE_0002);
        add_request(ACT_LOOKUP, dressed_name(0), '0, '0);
    endtask

    task automatic add_random();
        int pct;
        int k;
        for (int n = 0; n < RANDOM_REQ; n++)
        begin
            pct = $urandom_range(0, 99);
            k   = $urandom_range(0, POOL_SIZE - 1);
            if (pct < 40)
                add_request(ACT_BIND, dressed_name(k), rand_word(), rand_word());
            else if (pct < 65)
                add_request(ACT_LOOKUP, dressed_name(k), rand_word(), rand_word());
            else if (pct < 82)
                add_request(ACT_UNBIND, dressed_name(k), rand_word(), rand_word());
            else if (pct < 88)
            begin
                // bind with a zeroed handle or rights
                if ($urandom_range(0, 1))
                    add_request(ACT_BIND, dressed_name(k), 32'h0, rand_word());
                else
                    add_request(ACT_BIND, dressed_name(k), rand_word(), 32'h0);
            end
            else if (pct < 96)
                add_request(nbt_action_t'($urandom_range(0, 2)), broken_name(),
                            $urandom, $urandom);
            else
                add_request(ACT_RSVD, $urandom_range(0, 1) ? dressed_name(k) : rand128(),
                            $urandom, $urandom);
        end
    endtask

    // request driver: prediction happens at the accepting edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap  = 0;
            send_calm = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                reply_q.push_back(apply_request(request_t'(s_tdata)));
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (request_q.size() > 0)
                begin
                    s_tdata  <= request_q.pop_front();
                    s_tvalid <= 1'b1;
                    // calm stretches give back-to-back requests
                    if (send_calm > 0)
                        send_calm--;
                    else if ($urandom_range(0, 39) == 0)
                        send_calm = 60;
                    else
                        send_gap = idle_len();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // reply checker and receiver backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap  = 0;
            recv_calm = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_reply = reply_t'(m_tdata);
                replies_seen++;
                if (reply_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: reply with no request outstanding:", $realtime,
                                 " status %0d handle %h rights %h",
                                 got_reply.status, got_reply.handle, got_reply.rights);
                end
                else
                begin
                    want_reply = reply_q.pop_front();
                    if (got_reply.status != want_reply.status ||
                        got_reply.handle != want_reply.handle ||
                        got_reply.rights != want_reply.rights)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: reply mismatch:", $realtime,
                                     " want status %0d handle %h rights %h,",
                                     want_reply.status, want_reply.handle,
                                     want_reply.rights,
                                     " got status %0d handle %h rights %h",
                                     got_reply.status, got_reply.handle,
                                     got_reply.rights);
                    end
                end
            end
            if (hold_off)
                m_tready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (recv_calm > 0)
                    recv_calm--;
                else if ($urandom_range(0, 39) == 0)
                    recv_calm = 60;
                else if ($urandom_range(0, 2) == 0)
                    recv_gap = idle_len();
            end
        end
    end

    // long receiver stall mid-run so the block backs up into its input
    initial
    begin
        do
            @(negedge clk);
        while (replies_seen < 300);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // generous cap on the whole run
    initial
    begin
        #15_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        build_pool();
        add_directed();
        add_random();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        // drain: all requests taken and every reply back
        do
            @(negedge clk);
        while (request_q.size() != 0 || s_tvalid || reply_q.size() != 0);
        // room for a stray extra reply to show up
        repeat (40) @(posedge clk);
        if (errors == 0 && reply_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
